[rtl/polar_pushpull_with_angle_unwrap_defines.svh]
// Assertion macros for the push-pull limiter RTL.
// Each expects signals named clk and rst in the enclosing module.
`ifndef POLAR_PUSHPULL_WITH_ANGLE_UNWRAP_DEFINES_SVH
`define POLAR_PUSHPULL_WITH_ANGLE_UNWRAP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPAU_CHECK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppau: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPAU_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppau: next-cycle check failed");

`endif

[rtl/ppau_pkg.sv]
package ppau_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Field widths
  localparam int unsigned POS_W   = 24;
  localparam int unsigned CFG_W   = 23;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned ROT_W   = 32;
  localparam int unsigned ANGLE_W = 16;

  // CORDIC working widths: 8 guard bits plus headroom for the gain
  localparam int unsigned CX_W   = 36;
  localparam int unsigned ATAN_W = 24;

  localparam int unsigned ATAN_DEPTH = 24;
  localparam int unsigned ITER_W     = $clog2(ATAN_DEPTH);

  // Magnitude: final x times round(2^32 * 0.607252935), split in halves
  localparam int unsigned MUL_OP_W  = CX_W / 2;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned PROD_W    = MUL_OP_W + GAIN_W;
  localparam int unsigned MSUM_W    = PROD_W + MUL_OP_W;
  localparam int unsigned MAG_SHIFT = 40;
  localparam logic [GAIN_W-1:0] MAG_GAIN = 32'd2608131496;

  // Cap rescaling divide
  localparam int unsigned MAG_W = 24;
  localparam int unsigned QUO_W = 24;
  localparam int unsigned NUM_W = POS_W + CFG_W;

  localparam logic [ATAN_W-1:0] HALF_TURN   = 24'h800000;
  localparam logic [ATAN_W-1:0] ANGLE_ROUND = 24'd128;
  localparam logic [CFG_W-1:0]  DEADZONE_RESET = 23'd128;

  // Angle of 2^-i, units of 2^-24 turn
  localparam logic [ATAN_W-1:0] ATAN_TURNS [ATAN_DEPTH] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
    24'd166669,  24'd83416,   24'd41718,  24'd20860,
    24'd10430,   24'd5215,    24'd2608,   24'd1304,
    24'd652,     24'd326,     24'd163,    24'd81,
    24'd41,      24'd20,      24'd10,     24'd5,
    24'd3,       24'd1,       24'd1,      24'd0
  };

  typedef enum logic [CIDX_W-1:0] {
    REG_LIMIT_ENABLE,
    REG_MAX_PUSHPULL,
    REG_MAX_LINEAR,
    REG_DEADZONE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MAG_LO,
    ST_MAG_HI,
    ST_MAG_SUM,
    ST_LIMIT,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              load;
    logic              iter_en;
    logic              mag_lo;
    logic              mag_hi;
    logic              mag_sum;
    logic              div_load;
    logic              div_step;
    logic              finish;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic reset_item;
    logic cap;
  } stat_t;

endpackage

[rtl/ppau_div.sv]
module ppau_div import ppau_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [NUM_W-1:0] num,
  input  logic [MAG_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // Quotient is known to fit QUO_W bits, so the upper numerator bits seed the remainder.
  logic [MAG_W-1:0] rem;
  logic [QUO_W-1:0] nq;
  logic [MAG_W:0]   trial;
  logic             ge;

  assign trial = {rem, nq[QUO_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= MAG_W'(num[NUM_W-1:QUO_W]);
      nq  <= num[QUO_W-1:0];
    end else if (step) begin
      rem <= ge ? MAG_W'(trial - {1'b0, den}) : trial[MAG_W-1:0];
      nq  <= {nq[QUO_W-2:0], ge};
    end
  end

  assign quo = nq;

endmodule

[rtl/ppau_dpath.sv]
module ppau_dpath import ppau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    action,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  output logic signed [POS_W-1:0] limited_x,
  output logic signed [POS_W-1:0] limited_y,
  output logic [POS_W-1:0]        pull,
  output logic signed [ROT_W-1:0] rotation,
  output logic signed [POS_W-1:0] translation
);

  function automatic logic signed [POS_W-1:0] signed_sat(input logic neg,
                                                          input logic [QUO_W-1:0] q);
    logic signed [QUO_W:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > $signed({2'b00, {(POS_W-1){1'b1}}})) begin
      v = $signed({2'b00, {(POS_W-1){1'b1}}});
    end
    return v[POS_W-1:0];
  endfunction

  // Configuration
  logic             limit_enable;
  logic [CFG_W-1:0] max_pushpull;
  logic [CFG_W-1:0] max_linear;
  logic [CFG_W-1:0] deadzone;

  // Item registers
  logic                    reset_item;
  logic                    zero_vec;
  logic signed [POS_W-1:0] px, py, pz;

  // CORDIC
  logic signed [CX_W-1:0] cx, cy, xs, ys, x0, y0;
  logic [ATAN_W-1:0]      cz, atan;

  // Magnitude
  logic [MUL_OP_W-1:0] mul_op;
  logic [PROD_W-1:0]   mul_res, prod_lo, prod_hi;
  logic [MSUM_W-1:0]   mag_sum;
  logic [MSUM_W-MAG_SHIFT-1:0] mag_raw;
  logic [MAG_W-1:0]    mag, mag_next;

  // Cap
  logic             cap;
  logic [POS_W-1:0] ax, ay;
  logic [NUM_W-1:0] num_x, num_y;
  logic [QUO_W-1:0] qx, qy;

  // Channel state
  logic [ANGLE_W-1:0]      previous_angle;
  logic signed [ROT_W-1:0] rotation_total;
  logic signed [POS_W-1:0] held_translation;

  // Result
  logic [ATAN_W-1:0]         angle_sum;
  logic [ANGLE_W-1:0]        angle;
  logic signed [ANGLE_W+1:0] d_raw, d_wrap;
  logic signed [ROT_W:0]     rot_sum;
  logic signed [ROT_W-1:0]   rot_next;
  logic signed [POS_W:0]     pz_ext, lin;
  logic signed [POS_W-1:0]   held_next;
  logic signed [POS_W-1:0]   lx, ly;
  logic [MAG_W-1:0]          pull_sel, pull_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enable <= 1'b0;
      max_pushpull <= '0;
      max_linear   <= '0;
      deadzone     <= DEADZONE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        REG_MAX_PUSHPULL: max_pushpull <= cfg_data;
        REG_MAX_LINEAR:   max_linear   <= cfg_data;
        REG_DEADZONE:     deadzone     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pre-rotate by a half turn when x is negative
  assign x0 = $signed({{(CX_W-POS_W-8){pos_x[POS_W-1]}}, pos_x, 8'h00});
  assign y0 = $signed({{(CX_W-POS_W-8){pos_y[POS_W-1]}}, pos_y, 8'h00});

  assign xs   = cx >>> cmd.iter;
  assign ys   = cy >>> cmd.iter;
  assign atan = ATAN_TURNS[cmd.iter];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      reset_item <= action;
      zero_vec   <= (pos_x == '0) && (pos_y == '0);
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
      if (pos_x[POS_W-1]) begin
        cx <= -x0;
        cy <= -y0;
        cz <= HALF_TURN;
      end else begin
        cx <= x0;
        cy <= y0;
        cz <= '0;
      end
    end else if (cmd.iter_en) begin
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan;
      end
    end
  end

  // One shared multiplier, low half then high half of x
  assign mul_op  = cmd.mag_hi ? cx[CX_W-1:MUL_OP_W] : cx[MUL_OP_W-1:0];
  assign mul_res = PROD_W'(mul_op) * PROD_W'(MAG_GAIN);
  assign mag_sum = {prod_hi, {MUL_OP_W{1'b0}}} + MSUM_W'(prod_lo)
                 + (MSUM_W'(1) << (MAG_SHIFT - 1));
  assign mag_raw = mag_sum[MSUM_W-1:MAG_SHIFT];

  always_comb begin
    if (zero_vec || !(cx > 0)) begin
      mag_next = '0;
    end else if (|mag_raw[MSUM_W-MAG_SHIFT-1:MAG_W]) begin
      mag_next = '1;
    end else begin
      mag_next = mag_raw[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mag_lo) begin
      prod_lo <= mul_res;
    end
    if (cmd.mag_hi) begin
      prod_hi <= mul_res;
    end
    if (cmd.mag_sum) begin
      mag <= mag_next;
    end
  end

  assign cap = limit_enable && (mag > {1'b0, max_pushpull});

  assign ax    = px[POS_W-1] ? POS_W'(~px + 1'b1) : POS_W'(px);
  assign ay    = py[POS_W-1] ? POS_W'(~py + 1'b1) : POS_W'(py);
  assign num_x = NUM_W'(ax) * NUM_W'(max_pushpull) + NUM_W'(mag >> 1);
  assign num_y = NUM_W'(ay) * NUM_W'(max_pushpull) + NUM_W'(mag >> 1);

  ppau_div u_div_x (
    .clk  (clk),
    .load (cmd.div_load),
    .step (cmd.div_step),
    .num  (num_x),
    .den  (mag),
    .quo  (qx)
  );

  ppau_div u_div_y (
    .clk  (clk),
    .load (cmd.div_load),
    .step (cmd.div_step),
    .num  (num_y),
    .den  (mag),
    .quo  (qy)
  );

  assign angle_sum = cz + ANGLE_ROUND;
  assign angle     = zero_vec ? '0 : angle_sum[ATAN_W-1:ATAN_W-ANGLE_W];

  // Wrap the angle step into half a turn either way
  assign d_raw = $signed({2'b00, angle}) - $signed({2'b00, previous_angle});
  always_comb begin
    d_wrap = d_raw;
    if (d_raw > 0) begin
      if (d_raw >= 18'sd32768) begin
        d_wrap = d_raw - 18'sd65536;
      end
    end else if (d_raw <= -18'sd32768) begin
      d_wrap = d_raw + 18'sd65536;
    end
  end

  assign rot_sum = $signed({rotation_total[ROT_W-1], rotation_total})
                 + $signed({{(ROT_W-ANGLE_W-1){d_wrap[ANGLE_W+1]}}, d_wrap});
  always_comb begin
    if (rot_sum[ROT_W] != rot_sum[ROT_W-1]) begin
      rot_next = rot_sum[ROT_W] ? $signed({1'b1, {(ROT_W-1){1'b0}}})
                                : $signed({1'b0, {(ROT_W-1){1'b1}}});
    end else begin
      rot_next = rot_sum[ROT_W-1:0];
    end
  end

  assign pz_ext = $signed({pz[POS_W-1], pz});
  assign lin    = $signed({2'b00, max_linear});
  always_comb begin
    if (!limit_enable) begin
      held_next = held_translation;
    end else if (pz_ext > lin) begin
      held_next = lin[POS_W-1:0];
    end else if (pz_ext < -lin) begin
      held_next = POS_W'(-lin);
    end else begin
      held_next = pz;
    end
  end

  assign lx = cap ? signed_sat(px[POS_W-1], qx) : px;
  assign ly = cap ? signed_sat(py[POS_W-1], qy) : py;

  assign pull_sel  = cap ? {1'b0, max_pushpull} : mag;
  assign pull_next = (pull_sel <= {1'b0, deadzone}) ? '0 : pull_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_angle   <= '0;
      rotation_total   <= '0;
      held_translation <= '0;
    end else if (cmd.finish) begin
      if (reset_item) begin
        previous_angle   <= '0;
        rotation_total   <= '0;
        held_translation <= '0;
      end else begin
        previous_angle   <= angle;
        rotation_total   <= rot_next;
        held_translation <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (reset_item) begin
        limited_x   <= '0;
        limited_y   <= '0;
        pull        <= '0;
        rotation    <= '0;
        translation <= '0;
      end else begin
        limited_x   <= lx;
        limited_y   <= ly;
        pull        <= pull_next;
        rotation    <= rot_next;
        translation <= held_next;
      end
    end
  end

  assign stat.reset_item = reset_item;
  assign stat.cap        = cap;

endmodule

[rtl/ppau_ctrl.sv]
`include "polar_pushpull_with_angle_unwrap_defines.svh"

module ppau_ctrl import ppau_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t            state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iter      <= iter_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    cmd.iter   = iter;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          iter_next  = '0;
          state_next = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (stat.reset_item) begin
          state_next = ST_FINISH;
        end else begin
          cmd.iter_en = 1'b1;
          if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
            iter_next  = '0;
            state_next = ST_MAG_LO;
          end else begin
            iter_next = iter + 1'b1;
          end
        end
      end
      ST_MAG_LO: begin
        cmd.mag_lo = 1'b1;
        state_next = ST_MAG_HI;
      end
      ST_MAG_HI: begin
        cmd.mag_hi = 1'b1;
        state_next = ST_MAG_SUM;
      end
      ST_MAG_SUM: begin
        cmd.mag_sum = 1'b1;
        state_next  = ST_LIMIT;
      end
      ST_LIMIT: begin
        if (stat.cap) begin
          cmd.div_load = 1'b1;
          iter_next    = '0;
          state_next   = ST_DIVIDE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (iter == ITER_W'(QUO_W - 1)) begin
          iter_next  = '0;
          state_next = ST_FINISH;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall       = (state != ST_IDLE);
  assign out_valid_next = (out_valid && out_stall) || cmd.finish;

  `PPAU_CHECK_NEXT(a_accept_starts, in_valid && !in_stall, state == ST_CORDIC)
  `PPAU_CHECK_SAME(a_finish_free, cmd.finish, !out_valid || !out_stall)
  `PPAU_CHECK_NEXT(a_finish_shows, cmd.finish, out_valid)
  `PPAU_CHECK_SAME(a_iter_bound, state == ST_CORDIC, iter < ITER_W'(CORDIC_STEPS))

endmodule

[rtl/polar_pushpull_with_angle_unwrap.sv]
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+----------------------------------------
// in        | in_valid / in_stall         | action, pos_x, pos_y, pos_z
// out       | out_valid / out_stall       | limited_x, limited_y, pull, rotation,
//           |                             | translation
// cfg       | cfg_wr_en (no wait)         | cfg_index, cfg_data
//
// Flow: one item at a time. A sample passes through the load, the single CORDIC
// stage iterating once per step, the magnitude states and the limit check; when
// the cap applies, the bit-serial rescaling divide follows. A reset item goes
// from the CORDIC state straight to the finish.
// Reset: rst clears the channel state and config registers (dead zone to 0.5 mm).
// Stalls: the result register frees the core, so the next item is taken while a
// finished result waits; the core holds in its last step if a second result is
// ready before the first is taken.
module polar_pushpull_with_angle_unwrap import ppau_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_wr_en,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // item in
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  // item out
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] limited_x,
  output logic signed [POS_W-1:0] limited_y,
  output logic [POS_W-1:0]        pull,
  output logic signed [ROT_W-1:0] rotation,
  output logic signed [POS_W-1:0] translation
);

  // Controller sequences the datapath: load, iterate the CORDIC stage,
  // form the magnitude, optionally divide for the cap, then commit.
  cmd_t  cmd;
  stat_t stat;

  ppau_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath holds the registers, the CORDIC stage, the shared gain
  // multiplier, two divider lanes, the channel state and the result register.
  ppau_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .cmd         (cmd),
    .stat        (stat),
    .limited_x   (limited_x),
    .limited_y   (limited_y),
    .pull        (pull),
    .rotation    (rotation),
    .translation (translation)
  );

endmodule

[dv/polar_pushpull_with_angle_unwrap_test.sv]
module polar_pushpull_with_angle_unwrap_test;
  import ppau_pkg::*;

  // Bench constants
  localparam int unsigned STEPS = CORDIC_STEPS_DEF;
  // The longest sample runs through the divide; leave margin on top.
  localparam int SETTLE = 2 * (CORDIC_STEPS_DEF + 6 + 24);
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 90;
  localparam int N_PHASES = 5;
  localparam int SWEEP_STEP = 32700;      // just short of a half turn per item
  localparam int SWEEP_BOUND = 40;        // items in the half-turn sweep
  localparam real SWEEP_RADIUS = 4.0e6;
  localparam real TWO_PI = 6.283185307179586;
  // Watchdog limit for a full run, with a wide margin.
  localparam longint RUN_LIMIT = 10_000_000;

  localparam logic signed [POS_W-1:0] MAXC = 24'sh7F_FFFF;
  localparam logic signed [POS_W-1:0] MINC = 24'sh80_0000;

  // Angle of 2^-i in units of 2^-24 turn, kept apart from the design's own table
  localparam logic [23:0] ARCTAN_LUT [24] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
    24'd166669,  24'd83416,   24'd41718,  24'd20860,
    24'd10430,   24'd5215,    24'd2608,   24'd1304,
    24'd652,     24'd326,     24'd163,    24'd81,
    24'd41,      24'd20,      24'd10,     24'd5,
    24'd3,       24'd1,       24'd1,      24'd0
  };

  typedef struct packed {
    logic                    action;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [POS_W-1:0] lx;
    logic signed [POS_W-1:0] ly;
    logic [POS_W-1:0]        pull;
    logic signed [ROT_W-1:0] rot;
    logic signed [POS_W-1:0] trans;
  } polar_res_t;

  typedef struct packed {
    sample_t    smp;
    logic       typed;
    polar_res_t want;
  } dir_row_t;

  typedef enum int {SINK_OPEN, SINK_SPARSE, SINK_HALF, SINK_PERIODIC} sink_mode_t;

  localparam polar_res_t ZERO_RES = '0;

  // Directed table: typed results only where they are plain zeros.
  localparam dir_row_t DIR_ROWS [20] = '{
    '{'{1'b0, 24'sd0, 24'sd0, MAXC}, 1'b1, ZERO_RES},          // zero vector, z at top
    '{'{1'b0, 24'sd0, 24'sd0, MINC}, 1'b1, ZERO_RES},          // zero vector, z at bottom
    '{'{1'b1, -24'sd1, -24'sd1, -24'sd1}, 1'b1, ZERO_RES},     // channel reset, junk payload
    '{'{1'b0, MAXC, 24'sd0, MAXC}, 1'b0, ZERO_RES},
    '{'{1'b0, MINC, 24'sd0, MINC}, 1'b0, ZERO_RES},            // half-turn step, unwrapped backwards
    '{'{1'b0, MAXC, 24'sd0, 24'sd0}, 1'b0, ZERO_RES},          // and back again
    '{'{1'b0, 24'sd0, MAXC, 24'sd256}, 1'b0, ZERO_RES},
    '{'{1'b0, 24'sd0, MINC, -24'sd256}, 1'b0, ZERO_RES},
    '{'{1'b0, MINC, MINC, MAXC}, 1'b0, ZERO_RES},              // largest magnitude
    '{'{1'b0, MAXC, MAXC, MINC}, 1'b0, ZERO_RES},
    '{'{1'b0, 24'sd128, 24'sd0, 24'sd0}, 1'b0, ZERO_RES},      // on the dead zone edge
    '{'{1'b0, 24'sd129, 24'sd0, 24'sd0}, 1'b0, ZERO_RES},      // just past it
    '{'{1'b0, 24'sd1, 24'sd0, 24'sd1}, 1'b0, ZERO_RES},
    '{'{1'b0, -24'sd1, 24'sd0, -24'sd1}, 1'b0, ZERO_RES},
    '{'{1'b0, 24'sd0, 24'sd1, 24'sd0}, 1'b0, ZERO_RES},
    '{'{1'b0, 24'sd0, -24'sd1, 24'sd0}, 1'b0, ZERO_RES},
    '{'{1'b0, -24'sd256, 24'sd1, 24'sd0}, 1'b0, ZERO_RES},     // either side of the half turn
    '{'{1'b0, -24'sd256, -24'sd1, 24'sd0}, 1'b0, ZERO_RES},
    '{'{1'b0, 24'sd300, -24'sd200, 24'sd1234}, 1'b0, ZERO_RES},
    '{'{1'b1, MAXC, MINC, MAXC}, 1'b1, ZERO_RES}               // reset after activity
  };

  // DUT ports
  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  cfg_reg_t                cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    action;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] limited_x;
  logic signed [POS_W-1:0] limited_y;
  logic [POS_W-1:0]        pull;
  logic signed [ROT_W-1:0] rotation;
  logic signed [POS_W-1:0] translation;

  // Shadow registers and channel state of the predictor
  logic                    lim_en;
  logic [CFG_W-1:0]        cap_q;
  logic [CFG_W-1:0]        lin_q;
  logic [CFG_W-1:0]        dz_q;
  logic [ANGLE_W-1:0]      prev_angle_q;
  int                      rot_total_q;
  logic signed [POS_W-1:0] held_z_q;

  polar_res_t pending_results [$];
  int items_sent;
  int results_seen;
  int mismatches;
  bit hold_request;
  bit rx_free;

  polar_pushpull_with_angle_unwrap #(.CORDIC_STEPS(STEPS)) u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Rescale one coordinate onto the magnitude cap, rounding half away from zero.
  function automatic logic signed [POS_W-1:0] rescale_coord(logic signed [POS_W-1:0] c,
                                                            logic [63:0] cap,
                                                            logic [63:0] magn);
    longint v;
    logic [63:0] a;
    logic [63:0] q;
    v = c;
    a = (v < 0) ? -v : v;
    q = (a * cap + magn / 2) / magn;
    v = q;
    if (c < 0) v = -v;
    if (v > 64'sd8388607) v = 64'sd8388607;
    else if (v < -64'sd8388608) v = -64'sd8388608;
    return v[POS_W-1:0];
  endfunction

  // Work out the result of one accepted item and advance the channel state.
  function automatic polar_res_t polar_step(sample_t s);
    longint cx;
    longint cy;
    longint sx;
    longint sy;
    longint dlt;
    longint acc;
    longint zc;
    longint lin;
    logic [31:0] turn_acc;
    logic [31:0] rounded;
    logic [63:0] ux;
    logic [63:0] magn;
    logic [63:0] pl;
    logic [ANGLE_W-1:0] ang;
    logic signed [POS_W-1:0] lx;
    logic signed [POS_W-1:0] ly;
    polar_res_t r;
    r = '0;
    if (s.action) begin
      prev_angle_q = '0;
      rot_total_q = 0;
      held_z_q = '0;
      return r;
    end
    if (s.x == 0 && s.y == 0) begin
      ang = '0;
      magn = '0;
    end else begin
      cx = $signed(s.x);
      cy = $signed(s.y);
      cx = cx * 256;
      cy = cy * 256;
      turn_acc = '0;
      // pre-rotate by half a turn so the vector lies in the right half plane
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        turn_acc = 32'h0080_0000;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cy > 0) begin
          cx = cx + sy;
          cy = cy - sx;
          turn_acc = turn_acc + ARCTAN_LUT[i];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          turn_acc = turn_acc - ARCTAN_LUT[i];
        end
      end
      rounded = turn_acc + 32'd128;
      ang = rounded[23:8];
      ux = cx;
      magn = (cx > 0) ? ((ux * 64'd2608131496 + 64'h80_0000_0000) >> 40) : 64'd0;
      if (magn > 64'hFF_FFFF) magn = 64'hFF_FFFF;
    end

    lx = s.x;
    ly = s.y;
    pl = magn;
    if (lim_en && magn > cap_q) begin
      lx = rescale_coord(s.x, cap_q, magn);
      ly = rescale_coord(s.y, cap_q, magn);
      pl = cap_q;
    end
    if (pl <= dz_q) pl = '0;

    // unwrap the angle step into [-half turn, +half turn]
    dlt = longint'(ang) - longint'(prev_angle_q);
    if (dlt > 0) begin
      if (dlt >= 32768) dlt = dlt - 65536;
    end else if (dlt <= -32768) begin
      dlt = dlt + 65536;
    end
    acc = rot_total_q + dlt;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    rot_total_q = int'(acc);
    prev_angle_q = ang;

    if (lim_en) begin
      lin = lin_q;
      zc = $signed(s.z);
      if (zc > lin) zc = lin;
      else if (zc < -lin) zc = -lin;
      held_z_q = zc[POS_W-1:0];
    end

    r.lx = lx;
    r.ly = ly;
    r.pull = pl[POS_W-1:0];
    r.rot = rot_total_q;
    r.trans = held_z_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s, got %h, want %h (result %0d)",
             $time, what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic check_result(polar_res_t got);
    polar_res_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(got.pull), '0);
    end else begin
      want = pending_results.pop_front();
      if (got.lx !== want.lx) report_mismatch("limited_x", 32'(got.lx), 32'(want.lx));
      if (got.ly !== want.ly) report_mismatch("limited_y", 32'(got.ly), 32'(want.ly));
      if (got.pull !== want.pull) report_mismatch("pull", 32'(got.pull), 32'(want.pull));
      if (got.rot !== want.rot) report_mismatch("rotation", got.rot, want.rot);
      if (got.trans !== want.trans)
        report_mismatch("translation", 32'(got.trans), 32'(want.trans));
    end
  endtask

  // Sample results on the falling edge: the payload is settled and the item
  // is taken at the next rising edge whenever valid is high and stall low.
  always @(negedge clk) begin : result_monitor
    polar_res_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{limited_x, limited_y, pull, rotation, translation};
      check_result(got);
    end
  end

  // Receiver: stall on patterns of its own, with one long hold on request
  // and a free-running stretch for the rotation sweep.
  initial begin : result_sink
    int hold_left;
    int mode_left;
    int tick;
    sink_mode_t stall_mode;
    hold_left = 0;
    mode_left = 0;
    tick = 0;
    stall_mode = SINK_OPEN;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (rx_free) begin
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          stall_mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
          SINK_OPEN:   out_stall <= 1'b0;
          SINK_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
          SINK_HALF:   out_stall <= ($urandom_range(0, 1) == 0);
          default:     out_stall <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  // Offer one item and hold it until taken; record its expected result then.
  // Call at a rising edge; valid is left high for a following item.
  task automatic offer_sample(sample_t s, logic use_typed, polar_res_t typed_res);
    logic taken;
    polar_res_t want;
    in_valid <= 1'b1;
    action <= s.action;
    pos_x <= s.x;
    pos_y <= s.y;
    pos_z <= s.z;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    want = polar_step(s);
    pending_results.push_back(use_typed ? typed_res : want);
    items_sent++;
  endtask

  // Write all four registers back to back; call only with the channel idle.
  task automatic set_limits(logic [CFG_W-1:0] enable_word, logic [CFG_W-1:0] cap,
                            logic [CFG_W-1:0] lin, logic [CFG_W-1:0] dz);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LIMIT_ENABLE;
    cfg_data <= enable_word;
    @(posedge clk);
    cfg_index <= REG_MAX_PUSHPULL;
    cfg_data <= cap;
    @(posedge clk);
    cfg_index <= REG_MAX_LINEAR;
    cfg_data <= lin;
    @(posedge clk);
    cfg_index <= REG_DEADZONE;
    cfg_data <= dz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    // only the low bit of the enable word is kept
    lim_en = enable_word[0];
    cap_q = cap;
    lin_q = lin;
    dz_q = dz;
  endtask

  // Hold until every expected result has come, then let the core settle.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Spread of magnitudes: full range, near the dead zone, extremes, zero, log-uniform.
  function automatic logic signed [POS_W-1:0] pick_coord();
    int v;
    case ($urandom_range(0, 5))
      0: return POS_W'($urandom);
      1: begin
        v = $urandom_range(0, 1200);
        return POS_W'(v - 600);
      end
      2: return ($urandom_range(0, 1) == 0) ? MAXC : MINC;
      3: return '0;
      default: begin
        v = int'($urandom >> $urandom_range(9, 31));
        return POS_W'(($urandom_range(0, 1) == 0) ? -v : v);
      end
    endcase
  endfunction

  function automatic sample_t gen_sample();
    sample_t s;
    s.action = ($urandom_range(0, 19) == 0);
    s.x = pick_coord();
    s.y = pick_coord();
    s.z = pick_coord();
    return s;
  endfunction

  // Bursts of random length with random gaps; always end with valid low.
  task automatic drive_random(int count);
    int done_n;
    int burst;
    int gap;
    done_n = 0;
    while (done_n < count) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && done_n < count; b++) begin
        offer_sample(gen_sample(), 1'b0, ZERO_RES);
        done_n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (done_n >= count && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    sample_t s;
    longint sweep;
    real ang_r;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_LIMIT_ENABLE;
    cfg_data = '0;
    in_valid = 1'b0;
    action = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    hold_request = 1'b0;
    rx_free = 1'b0;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    // register and channel values after reset
    lim_en = 1'b0;
    cap_q = '0;
    lin_q = '0;
    dz_q = DEADZONE_RESET;
    prev_angle_q = '0;
    rot_total_q = 0;
    held_z_q = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under reset register values
    foreach (DIR_ROWS[i]) offer_sample(DIR_ROWS[i].smp, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own limiter setting
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_limits(23'd1, CFG_W'($urandom_range(50000, 3000000)),
                      CFG_W'($urandom_range(0, 4000000)), DEADZONE_RESET);
        1: set_limits(23'd1, '0, '0, '0);
        2: set_limits('1, '1, '1, '1);
        3: set_limits(23'h7F_FFFE, CFG_W'($urandom), CFG_W'($urandom),
                      CFG_W'($urandom_range(0, 2000)));
        default: set_limits(23'd1, CFG_W'($urandom >> $urandom_range(9, 20)),
                            CFG_W'($urandom >> 9), CFG_W'($urandom_range(0, 4000)));
      endcase
      // first phase: block the output for a long stretch so the input backs up
      if (p == 0) hold_request = 1'b1;
      drive_random(PHASE_ITEMS);
      wait_drained();
    end

    // Sweep the angle by just under half a turn per item, back to back with
    // the receiver open, then clear the channel with a reset item.
    rx_free = 1'b1;
    sweep = 0;
    while (sweep < SWEEP_BOUND) begin
      ang_r = TWO_PI * real'((sweep * SWEEP_STEP) % 65536) / 65536.0;
      s.action = 1'b0;
      s.x = POS_W'(int'(SWEEP_RADIUS * $cos(ang_r)));
      s.y = POS_W'(int'(SWEEP_RADIUS * $sin(ang_r)));
      s.z = POS_W'($urandom);
      offer_sample(s, 1'b0, ZERO_RES);
      sweep++;
    end
    s = '0;
    s.action = 1'b1;
    offer_sample(s, 1'b0, ZERO_RES);
    in_valid <= 1'b0;
    wait_drained();
    rx_free = 1'b0;

    $display("Run covered %0d items: directed table, %0d limiter settings with random stalls,",
             items_sent, N_PHASES);
    $display("and a sweep of %0d items stepping just under half a turn; %0d results checked",
             sweep, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
